[rtl/bmft_pkg.sv]
`default_nettype none

package bmft_pkg;

  // Default geometry of the flash array.
  localparam int NUM_BLOCKS        = 64;
  localparam int SECTORS_PER_BLOCK = 32;
  localparam int DATA_BITS         = 32;

  // Fixed field widths of the command and result words.
  localparam int LSN_W  = 16;
  localparam int WORD_W = 32;
  localparam int CNT_W  = 32;
  // Wide enough for the largest per-cycle read increment (a whole block).
  localparam int INC_W  = 9;

  // Command codes.
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_COUNT = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_NOFREE = 2'd2;

  // Per-cycle update request for the operation counters.
  typedef struct packed {
    logic             clr;
    logic [INC_W-1:0] rd_inc;
    logic             wr_inc;
    logic             er_inc;
  } bmft_cnt_t;

endpackage

`default_nettype wire

[rtl/bmft_ram.sv]
`default_nettype none

module bmft_ram #(
  parameter int Width = 8,
  parameter int Depth = 2,
  localparam int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/bmft_cnt.sv]
`default_nettype none

module bmft_cnt (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire bmft_pkg::bmft_cnt_t       ctl_i,
  output logic [bmft_pkg::CNT_W-1:0]     read_total_o,
  output logic [bmft_pkg::CNT_W-1:0]     write_total_o,
  output logic [bmft_pkg::CNT_W-1:0]     erase_total_o
);
  import bmft_pkg::*;

  logic [CNT_W-1:0] rd_q, rd_d, wr_q, wr_d, er_q, er_d;
  logic [CNT_W:0]   rd_sum, wr_sum, er_sum;

  // Saturating additions; a clear wins over any increment.
  assign rd_sum = {1'b0, rd_q} + (CNT_W + 1)'(ctl_i.rd_inc);
  assign wr_sum = {1'b0, wr_q} + (CNT_W + 1)'(ctl_i.wr_inc);
  assign er_sum = {1'b0, er_q} + (CNT_W + 1)'(ctl_i.er_inc);

  always_comb begin
    rd_d = rd_sum[CNT_W] ? '1 : rd_sum[CNT_W-1:0];
    wr_d = wr_sum[CNT_W] ? '1 : wr_sum[CNT_W-1:0];
    er_d = er_sum[CNT_W] ? '1 : er_sum[CNT_W-1:0];
    if (ctl_i.clr) begin
      rd_d = '0;
      wr_d = '0;
      er_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0;
      wr_q <= '0;
      er_q <= '0;
    end else begin
      rd_q <= rd_d;
      wr_q <= wr_d;
      er_q <= er_d;
    end
  end

  assign read_total_o  = rd_q;
  assign write_total_o = wr_q;
  assign erase_total_o = er_q;

endmodule

`default_nettype wire

[rtl/block_mapped_flash_translation_core.sv]
// A read or direct write passes through the divide, map read, map wait and sector wait
// states before its result; count, unused and out-of-range commands go straight to the
// result. A nonzero direct write into an erased block first zeroes the rest of that block.
// A merging write scans the block flags (up to NumBlocks of them), copies the block through
// the sector RAM into the new block and sweeps the block map.
// One word is in flight at a time; the next word is taken while the last result waits.
// Reset is immediate: block flags and map valid bits clear at once, no clearing pass.
`default_nettype none

module block_mapped_flash_translation_core #(
  parameter int NumBlocks       = bmft_pkg::NUM_BLOCKS,
  parameter int SectorsPerBlock = bmft_pkg::SECTORS_PER_BLOCK,
  parameter int DataBits        = bmft_pkg::DATA_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    cmd_i,
  input  wire logic [bmft_pkg::LSN_W-1:0]    logical_sector_i,
  input  wire logic [bmft_pkg::WORD_W-1:0]   write_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [bmft_pkg::WORD_W-1:0]        read_data_o,
  output logic [1:0]                         status_o,
  output logic [bmft_pkg::CNT_W-1:0]         read_total_o,
  output logic [bmft_pkg::CNT_W-1:0]         write_total_o,
  output logic [bmft_pkg::CNT_W-1:0]         erase_total_o,
  output logic                               did_merge_o
);
  import bmft_pkg::*;

  localparam int TotalSectors = NumBlocks * SectorsPerBlock;
  localparam int BW = $clog2(NumBlocks);
  localparam int OW = $clog2(SectorsPerBlock);
  localparam int AW = $clog2(TotalSectors);
  localparam int SW = (DataBits < WORD_W) ? DataBits : WORD_W;
  localparam int MW = (BW > OW) ? BW : OW;
  localparam int CW = ((MW > 4) ? MW : 4) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_MAPRD, S_MAPWT, S_SECWT, S_ZERO, S_SCAN, S_COPY, S_MAPSW, S_OUT
  } state_e;

  state_e            state_q, state_d;
  logic [1:0]        cmd_q, cmd_d;
  logic [LSN_W-1:0]  lsn_sh_q, lsn_sh_d, quo_q, quo_d;
  logic [OW-1:0]     rem_q, rem_d;
  logic [SW-1:0]     data_q, data_d;
  logic [BW-1:0]     oldb_q, oldb_d, newb_q, newb_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic              nz_q, nz_d;
  logic [NumBlocks-1:0] bflag_q, bflag_d, mvalid_q, mvalid_d;
  logic [SW-1:0]     res_rd_q, res_rd_d;
  logic [1:0]        res_st_q, res_st_d;
  logic [CNT_W-1:0]  res_rt_q, res_rt_d, res_wt_q, res_wt_d, res_et_q, res_et_d;
  logic              res_mg_q, res_mg_d;
  logic              out_valid_q, out_valid_d, out_load;
  logic [SW-1:0]     out_rd_q;
  logic [1:0]        out_st_q;
  logic [CNT_W-1:0]  out_rt_q, out_wt_q, out_et_q;
  logic              out_mg_q;

  logic              s_we, m_we;
  logic [AW-1:0]     s_waddr, s_raddr;
  logic [SW-1:0]     s_wdata, s_rdata;
  logic [BW-1:0]     m_waddr, m_raddr, m_wdata, m_rdata;
  bmft_cnt_t         cnt_ctl;
  logic [CNT_W-1:0]  rd_total, wr_total, er_total;

  logic [BW-1:0]     lbn, map_val, mv_idx, mv;
  logic [SW-1:0]     word, cword;
  logic [CW-1:0]     cidx;

  // Physical sector address of a block and offset.
  function automatic logic [AW-1:0] phys(input logic [BW-1:0] b, input logic [OW-1:0] o);
    return AW'(b) * AW'(SectorsPerBlock) + AW'(o);
  endfunction

  assign lbn   = quo_q[BW-1:0];

  // A map entry never written holds the identity; a block not flagged reads as empty.
  assign map_val = mvalid_q[lbn] ? m_rdata : lbn;
  assign word    = bflag_q[oldb_q] ? s_rdata : '0;
  assign cidx    = idx_q - CW'(1);
  assign cword   = (cidx[OW-1:0] == rem_q) ? data_q : s_rdata;
  assign mv_idx  = cidx[BW-1:0];
  assign mv      = mvalid_q[mv_idx] ? m_rdata : mv_idx;

  // Command sequencer.
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    lsn_sh_d  = lsn_sh_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    data_d    = data_q;
    oldb_d    = oldb_q;
    newb_d    = newb_q;
    idx_d     = idx_q;
    nz_d      = nz_q;
    bflag_d   = bflag_q;
    mvalid_d  = mvalid_q;
    res_rd_d  = res_rd_q;
    res_st_d  = res_st_q;
    res_rt_d  = res_rt_q;
    res_wt_d  = res_wt_q;
    res_et_d  = res_et_q;
    res_mg_d  = res_mg_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_load  = 1'b0;
    s_we      = 1'b0;
    s_waddr   = '0;
    s_wdata   = '0;
    s_raddr   = '0;
    m_we      = 1'b0;
    m_waddr   = '0;
    m_wdata   = '0;
    m_raddr   = '0;
    cnt_ctl   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d    = cmd_i;
          lsn_sh_d = logical_sector_i;
          data_d   = SW'(write_data_i);
          quo_d    = '0;
          rem_d    = '0;
          idx_d    = '0;
          res_rd_d = '0;
          res_st_d = ST_OK;
          res_rt_d = '0;
          res_wt_d = '0;
          res_et_d = '0;
          res_mg_d = 1'b0;
          state_d  = S_OUT;
          if (cmd_i == CMD_COUNT) begin
            res_rt_d    = rd_total;
            res_wt_d    = wr_total;
            res_et_d    = er_total;
            cnt_ctl.clr = 1'b1;
          end else if (cmd_i == CMD_READ || cmd_i == CMD_WRITE) begin
            if (32'(logical_sector_i) >= 32'(TotalSectors)) begin
              res_st_d = ST_RANGE;
            end else begin
              state_d = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        // The block size is a power of two, so the split is a shift and a mask.
        quo_d   = lsn_sh_q >> OW;
        rem_d   = lsn_sh_q[OW-1:0];
        state_d = S_MAPRD;
      end
      S_MAPRD: begin
        m_raddr = lbn;
        state_d = S_MAPWT;
      end
      S_MAPWT: begin
        oldb_d         = map_val;
        s_raddr        = phys(map_val, rem_q);
        cnt_ctl.rd_inc = INC_W'(1);
        state_d        = S_SECWT;
      end
      S_SECWT: begin
        state_d = S_OUT;
        idx_d   = '0;
        if (cmd_q == CMD_READ) begin
          res_rd_d = word;
        end else if (word == '0) begin
          // Direct write into an empty sector.
          cnt_ctl.rd_inc = INC_W'(1);
          cnt_ctl.wr_inc = 1'b1;
          if (bflag_q[oldb_q]) begin
            s_we    = 1'b1;
            s_waddr = phys(oldb_q, rem_q);
            s_wdata = data_q;
          end else if (data_q != '0) begin
            // First live word in an erased block: zero the rest of it on the way.
            state_d = S_ZERO;
          end
        end else begin
          state_d = S_SCAN;
        end
      end
      S_ZERO: begin
        s_we    = 1'b1;
        s_waddr = phys(oldb_q, idx_q[OW-1:0]);
        s_wdata = (idx_q[OW-1:0] == rem_q) ? data_q : '0;
        idx_d   = idx_q + CW'(1);
        if (idx_q == CW'(SectorsPerBlock - 1)) begin
          bflag_d[oldb_q] = 1'b1;
          state_d         = S_OUT;
        end
      end
      S_SCAN: begin
        // One block flag a cycle; each block scanned counts as a full block of reads.
        cnt_ctl.rd_inc = INC_W'(SectorsPerBlock);
        if (!bflag_q[idx_q[BW-1:0]]) begin
          newb_d  = idx_q[BW-1:0];
          idx_d   = '0;
          nz_d    = 1'b0;
          state_d = S_COPY;
        end else if (idx_q == CW'(NumBlocks - 1)) begin
          res_st_d = ST_NOFREE;
          state_d  = S_OUT;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      S_COPY: begin
        // Read sector idx of the old block while sector idx-1 lands in the new one.
        if (idx_q < CW'(SectorsPerBlock)) begin
          s_raddr = phys(oldb_q, idx_q[OW-1:0]);
        end
        if (idx_q != '0) begin
          s_we           = 1'b1;
          s_waddr        = phys(newb_q, cidx[OW-1:0]);
          s_wdata        = cword;
          cnt_ctl.rd_inc = INC_W'(2);
          cnt_ctl.wr_inc = 1'b1;
          nz_d           = nz_q || (cword != '0);
        end
        idx_d = idx_q + CW'(1);
        if (idx_q == CW'(SectorsPerBlock)) begin
          bflag_d[newb_q] = nz_q || (cword != '0);
          bflag_d[oldb_q] = 1'b0;
          cnt_ctl.er_inc  = 1'b1;
          idx_d           = '0;
          state_d         = S_MAPSW;
        end
      end
      S_MAPSW: begin
        // Sweep the map and exchange the two physical block numbers.
        if (idx_q < CW'(NumBlocks)) begin
          m_raddr = idx_q[BW-1:0];
        end
        if (idx_q != '0) begin
          m_we             = 1'b1;
          m_waddr          = mv_idx;
          m_wdata          = (mv == newb_q) ? oldb_q : ((mv == oldb_q) ? newb_q : mv);
          mvalid_d[mv_idx] = 1'b1;
        end
        idx_d = idx_q + CW'(1);
        if (idx_q == CW'(NumBlocks)) begin
          res_mg_d = 1'b1;
          state_d  = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      lsn_sh_q    <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      data_q      <= '0;
      oldb_q      <= '0;
      newb_q      <= '0;
      idx_q       <= '0;
      nz_q        <= 1'b0;
      bflag_q     <= '0;
      mvalid_q    <= '0;
      res_rd_q    <= '0;
      res_st_q    <= ST_OK;
      res_rt_q    <= '0;
      res_wt_q    <= '0;
      res_et_q    <= '0;
      res_mg_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_rd_q    <= '0;
      out_st_q    <= ST_OK;
      out_rt_q    <= '0;
      out_wt_q    <= '0;
      out_et_q    <= '0;
      out_mg_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      lsn_sh_q    <= lsn_sh_d;
      quo_q       <= quo_d;
      rem_q       <= rem_d;
      data_q      <= data_d;
      oldb_q      <= oldb_d;
      newb_q      <= newb_d;
      idx_q       <= idx_d;
      nz_q        <= nz_d;
      bflag_q     <= bflag_d;
      mvalid_q    <= mvalid_d;
      res_rd_q    <= res_rd_d;
      res_st_q    <= res_st_d;
      res_rt_q    <= res_rt_d;
      res_wt_q    <= res_wt_d;
      res_et_q    <= res_et_d;
      res_mg_q    <= res_mg_d;
      out_valid_q <= out_valid_d;
      if (out_load) begin
        out_rd_q <= res_rd_q;
        out_st_q <= res_st_q;
        out_rt_q <= res_rt_q;
        out_wt_q <= res_wt_q;
        out_et_q <= res_et_q;
        out_mg_q <= res_mg_q;
      end
    end
  end

  // Sector store and block map.
  bmft_ram #(.Width(SW), .Depth(TotalSectors)) u_sector_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  bmft_ram #(.Width(BW), .Depth(NumBlocks)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i (m_wdata),
    .raddr_i (m_raddr),
    .rdata_o (m_rdata)
  );

  bmft_cnt u_cnt (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (cnt_ctl),
    .read_total_o  (rd_total),
    .write_total_o (wr_total),
    .erase_total_o (er_total)
  );

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign read_data_o   = WORD_W'(out_rd_q);
  assign status_o      = out_st_q;
  assign read_total_o  = out_rt_q;
  assign write_total_o = out_wt_q;
  assign erase_total_o = out_et_q;
  assign did_merge_o   = out_mg_q;

  // A merge result always reports success.
  a_merge_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && did_merge_o |-> status_o == ST_OK)
    else $error("merge reported with a failing status");

  // The copy ends by erasing the old block and moving on to the map sweep.
  a_copy_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_COPY && idx_q == CW'(SectorsPerBlock)
    |=> state_q == S_MAPSW && !bflag_q[oldb_q])
    else $error("old block not erased after copy");

  // The free-block scan only starts from a block that holds data.
  a_scan_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> bflag_q[oldb_q])
    else $error("scan started for an empty source block");

  // An out-of-range sector goes straight to the result with the range status.
  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (cmd_i == CMD_READ || cmd_i == CMD_WRITE)
    && 32'(logical_sector_i) >= 32'(TotalSectors)
    |=> state_q == S_OUT && res_st_q == ST_RANGE)
    else $error("out-of-range sector not rejected");

endmodule

`default_nettype wire

[test/tb_block_mapped_flash_translation_core.sv]
`timescale 1ns / 100ps
`default_nettype none

module tb_block_mapped_flash_translation_core;
  import bmft_pkg::*;

  localparam int NB = NUM_BLOCKS;
  localparam int SPB = SECTORS_PER_BLOCK;
  localparam int TOTAL = NB * SPB;
  localparam longint CMAX = 64'hFFFF_FFFF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int LIMIT = 3_000_000;

  typedef struct packed {
    logic [31:0] rdata;
    logic [1:0]  st;
    logic [31:0] rtot;
    logic [31:0] wtot;
    logic [31:0] etot;
    logic        merged;
  } flash_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] cmd_i = '0;
  logic [LSN_W-1:0] logical_sector_i = '0;
  logic [WORD_W-1:0] write_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [WORD_W-1:0] read_data_o;
  logic [1:0] status_o;
  logic [CNT_W-1:0] read_total_o, write_total_o, erase_total_o;
  logic did_merge_o;

  block_mapped_flash_translation_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .cmd_i(cmd_i), .logical_sector_i(logical_sector_i), .write_data_i(write_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .read_data_o(read_data_o), .status_o(status_o),
    .read_total_o(read_total_o), .write_total_o(write_total_o),
    .erase_total_o(erase_total_o), .did_merge_o(did_merge_o)
  );

  // Clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the flash array, block map and operation counters.
  logic [31:0] flash_words [TOTAL];
  int unsigned map_tbl [NB];
  longint rd_cnt, wr_cnt, er_cnt;

  flash_result_t expected_results [$];
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int merges_seen = 0;
  int nofree_seen = 0;
  longint cycle = 0;
  bit idle_enable = 1'b1;
  bit long_hold = 1'b0;

  function automatic void add_sat(ref longint c, input longint n);
    c = (c + n > CMAX) ? CMAX : c + n;
  endfunction

  function automatic void flash_reset();
    foreach (flash_words[i]) flash_words[i] = '0;
    foreach (map_tbl[i]) map_tbl[i] = i;
    rd_cnt = 0;
    wr_cnt = 0;
    er_cnt = 0;
  endfunction

  // Computes the result of one command and updates the shadow state.
  function automatic flash_result_t flash_translate(logic [1:0] cmd, logic [15:0] lsn,
                                                    logic [31:0] data);
    flash_result_t r;
    int unsigned lbn, off, oldb, newb, ps;
    bit empty;
    r = '0;
    if (cmd == CMD_COUNT) begin
      r.rtot = rd_cnt[31:0];
      r.wtot = wr_cnt[31:0];
      r.etot = er_cnt[31:0];
      rd_cnt = 0;
      wr_cnt = 0;
      er_cnt = 0;
    end else if (cmd == CMD_READ || cmd == CMD_WRITE) begin
      if (lsn >= TOTAL) begin
        r.st = ST_RANGE;
      end else begin
        lbn = lsn / SPB;
        off = lsn % SPB;
        oldb = map_tbl[lbn];
        ps = oldb * SPB + off;
        add_sat(rd_cnt, 1);
        if (cmd == CMD_READ) begin
          r.rdata = flash_words[ps];
        end else if (flash_words[ps] == 0) begin
          add_sat(rd_cnt, 1);
          add_sat(wr_cnt, 1);
          flash_words[ps] = data;
        end else begin
          // Find the lowest wholly empty physical block.
          newb = NB;
          for (int b = 0; b < NB && newb == NB; b++) begin
            add_sat(rd_cnt, SPB);
            empty = 1'b1;
            for (int s = 0; s < SPB; s++)
              if (flash_words[b * SPB + s] != 0) empty = 1'b0;
            if (empty) newb = b;
          end
          if (newb == NB) begin
            r.st = ST_NOFREE;
          end else begin
            for (int s = 0; s < SPB; s++) begin
              flash_words[newb * SPB + s] = (s == off) ? data : flash_words[oldb * SPB + s];
              add_sat(rd_cnt, 2);
              add_sat(wr_cnt, 1);
            end
            add_sat(er_cnt, 1);
            for (int s = 0; s < SPB; s++) flash_words[oldb * SPB + s] = '0;
            foreach (map_tbl[i]) begin
              if (map_tbl[i] == newb) map_tbl[i] = oldb;
              else if (map_tbl[i] == oldb) map_tbl[i] = newb;
            end
            r.merged = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch on result %0d: %s got %h expected %h", results_seen, what, got, want);
  endtask

  // Cycle counter with a run limit.
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("timeout after %0d cycles", cycle);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver stall: random bursts, or a long hold when requested.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        for (int i = 0; i < 400; i++) @(negedge clk_i);
        out_stall_i <= 1'b0;
        long_hold = 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    flash_result_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("result with nothing expected");
      end else begin
        w = expected_results.pop_front();
        if (read_data_o !== w.rdata) report_mismatch("read_data", read_data_o, w.rdata);
        if (status_o !== w.st) report_mismatch("status", status_o, w.st);
        if (read_total_o !== w.rtot) report_mismatch("read_total", read_total_o, w.rtot);
        if (write_total_o !== w.wtot) report_mismatch("write_total", write_total_o, w.wtot);
        if (erase_total_o !== w.etot) report_mismatch("erase_total", erase_total_o, w.etot);
        if (did_merge_o !== w.merged) report_mismatch("did_merge", did_merge_o, w.merged);
        if (w.merged) merges_seen++;
        if (w.st == ST_NOFREE) nofree_seen++;
      end
      results_seen++;
    end
  end

  // Offers one word, optionally after a random gap, and waits for acceptance.
  task automatic send_word(logic [1:0] cmd, logic [15:0] lsn, logic [31:0] data);
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    logical_sector_i <= lsn;
    write_data_i <= data;
    expected_results.push_back(flash_translate(cmd, lsn, data));
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_sector();
    return (16'($urandom_range(0, 9)) == 0) ? 16'($urandom) : 16'($urandom_range(0, TOTAL - 1));
  endfunction

  // Extremes, every command and the range, zero-data and unused-command cases.
  task automatic test_directed();
    send_word(CMD_READ, 16'd0, '0);
    send_word(CMD_WRITE, 16'd0, 32'hFFFF_FFFF);
    send_word(CMD_READ, 16'd0, '0);
    send_word(CMD_WRITE, 16'd0, 32'h0000_0001);
    send_word(CMD_READ, 16'd0, '0);
    send_word(CMD_WRITE, 16'(TOTAL - 1), 32'hA5A5_5A5A);
    send_word(CMD_WRITE, 16'(TOTAL - 1), 32'h0);
    send_word(CMD_READ, 16'(TOTAL - 1), '0);
    send_word(CMD_WRITE, 16'(TOTAL), 32'h1234_5678);
    send_word(CMD_READ, 16'hFFFF, '0);
    send_word(CMD_WRITE, 16'd33, 32'h0);
    send_word(CMD_READ, 16'd33, '0);
    send_word(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(CMD_COUNT, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(CMD_COUNT, 16'd0, '0);
    drain();
  endtask

  // Fill every block so the free-block scan fails.
  task automatic test_no_free_block();
    for (int b = 0; b < NB; b++) send_word(CMD_WRITE, 16'(b * SPB + 1), $urandom | 1);
    send_word(CMD_WRITE, 16'd1, 32'hDEAD_BEEF);
    send_word(CMD_READ, 16'd1, '0);
    send_word(CMD_COUNT, '0, '0);
    // Reads of every sector restore nothing, so empty blocks by overwriting is impossible;
    // the state stays full and later writes over full sectors keep reporting no free block.
    drain();
  endtask

  // Long receiver hold while the sender keeps offering words.
  task automatic test_backpressure();
    long_hold = 1'b1;
    for (int i = 0; i < 20; i++) send_word(CMD_READ, rand_sector(), '0);
    drain();
  endtask

  // Random mix of reads, writes, counts and unused commands; wrapping is fine since state is shadowed.
  task automatic test_random(int n);
    int k;
    logic [1:0] cmd;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      cmd = (k < 45) ? CMD_READ : (k < 92) ? CMD_WRITE : (k < 98) ? CMD_COUNT : CMD_UNUSED;
      send_word(cmd, rand_sector(), ($urandom_range(0, 15) == 0) ? 32'h0 : $urandom);
    end
  endtask

  initial begin
    flash_reset();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(500);
    drain();
    test_backpressure();
    test_no_free_block();
    test_random(600);
    idle_enable = 1'b0;
    test_random(250);
    send_word(CMD_COUNT, '0, '0);
    drain();
    repeat (200) @(negedge clk_i);
    $display("sent %0d words, checked %0d results, %0d merges, %0d no-free-block writes",
             words_sent, results_seen, merges_seen, nofree_seen);
    $display("covered reads, direct and merging writes, counts, range errors, back-pressure");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
